// File: design/sswc_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and sizes of the slot store with compaction.
package sswc_pkg;

	localparam int SLOTS = 128;
	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam logic [7:0] SLOTS_B = 8'(SLOTS);
	localparam logic [7:0] EMPTY_CODE = 8'd30;
	localparam logic [7:0] NO_SLOT = 8'd255;

	// free-slot search: groups of eight slots
	localparam int GRP_SZ = 8;
	localparam int GRP_BW = 3;
	localparam int GRP_N = (SLOTS + GRP_SZ - 1) / GRP_SZ;
	localparam int GRP_IW = (GRP_N > 1) ? $clog2(GRP_N) : 1;

	localparam logic [1:0] CMD_ADD = 2'd0;
	localparam logic [1:0] CMD_CLR = 2'd1;
	localparam logic [1:0] CMD_RD = 2'd2;
	localparam logic [1:0] CMD_CMP = 2'd3;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	typedef struct packed {
		logic [7:0] rtype;
		logic [7:0] spicy;
		logic [7:0] dry;
		logic [7:0] sweet;
		logic [7:0] bitter;
		logic [7:0] sour;
		logic [7:0] smooth;
	} rec_t;

	localparam int REC_W = $bits(rec_t);

	localparam rec_t EMPTY_REC = '{
		rtype: EMPTY_CODE, spicy: 8'd0, dry: 8'd0, sweet: 8'd0,
		bitter: 8'd0, sour: 8'd0, smooth: 8'd0
	};

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] slot_index;
		logic [7:0] in_type;
		logic [7:0] in_spicy;
		logic [7:0] in_dry;
		logic [7:0] in_sweet;
		logic [7:0] in_bitter;
		logic [7:0] in_sour;
		logic [7:0] in_smooth;
	} cmd_item_t;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] result_slot;
		logic [7:0] out_type;
		logic [7:0] out_spicy;
		logic [7:0] out_dry;
		logic [7:0] out_sweet;
		logic [7:0] out_bitter;
		logic [7:0] out_sour;
		logic [7:0] out_smooth;
		logic [7:0] filled_count;
	} rsp_item_t;

	// controller -> datapath
	typedef struct packed {
		logic load;          // input transfer, latch item and start read
		logic add_go;        // add: write lowest free slot
		logic clr_go;        // clear one slot
		logic cmp_step;      // compaction: handle one slot
		logic out_from_res;  // final cycle, output register free
		logic hold_from_res; // final cycle, output register busy
		logic out_from_hold;
	} dp_ctl_t;

	// datapath -> controller
	typedef struct packed {
		logic cmp_last;
	} dp_sts_t;

endpackage

// File: design/slot_store_with_compaction.sv
`timescale 1ns / 1ps
// Add, clear and read go from the transfer through one work state (S_ADD, S_CLR or S_RD) to the result.
// Compact walks the record memory in state S_CMP, one slot a cycle.
// A command is taken while the previous result still waits in the output register.
// Reset (arst_n low) empties every slot at once through per-slot valid flags and
// zeroes the filled count; no clearing pass is needed.
module slot_store_with_compaction (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_stall,
	input  sswc_pkg::cmd_item_t cmd_item,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output sswc_pkg::rsp_item_t rsp_item
);

	sswc_pkg::dp_ctl_t ctl;
	sswc_pkg::dp_sts_t sts;

	sswc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_code  (cmd_item.cmd),
		.cmd_stall (cmd_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.ctl       (ctl),
		.sts       (sts)
	);

	sswc_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_item (cmd_item),
		.ctl      (ctl),
		.sts      (sts),
		.rsp_item (rsp_item)
	);

endmodule

// File: design/sswc_ram.sv
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read data.
module sswc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: design/sswc_dp.sv
`timescale 1ns / 1ps
// Datapath: record memory, slot flags, free-slot search, count and result registers.
module sswc_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sswc_pkg::cmd_item_t  cmd_item,
	input  sswc_pkg::dp_ctl_t    ctl,
	output sswc_pkg::dp_sts_t    sts,
	output sswc_pkg::rsp_item_t  rsp_item
);

	localparam int PAD_W = sswc_pkg::GRP_N * sswc_pkg::GRP_SZ;

	sswc_pkg::cmd_item_t item_q;
	logic [sswc_pkg::SLOTS-1:0] valid_q;
	logic [sswc_pkg::SLOTS-1:0] used_q;
	logic [sswc_pkg::SLOTS-1:0] valid_d;
	logic [sswc_pkg::SLOTS-1:0] used_d;
	logic [7:0] cnt_q;
	logic [7:0] cnt_d;
	logic [sswc_pkg::SLOT_W-1:0] ptr_q;
	logic [sswc_pkg::SLOT_W-1:0] wr_ptr_q;

	// free-slot search, stage one runs every cycle
	logic [PAD_W-1:0] free_pad;
	logic [sswc_pkg::GRP_N-1:0] grp_any_d;
	logic [sswc_pkg::GRP_BW-1:0] grp_pos_d [sswc_pkg::GRP_N];
	logic [sswc_pkg::GRP_N-1:0] grp_any_s1;
	logic [sswc_pkg::GRP_BW-1:0] grp_pos_s1 [sswc_pkg::GRP_N];

	logic found;
	logic [sswc_pkg::GRP_IW-1:0] grp_sel;
	logic [sswc_pkg::GRP_IW+sswc_pkg::GRP_BW-1:0] add_slot_w;
	logic [sswc_pkg::SLOT_W-1:0] add_slot;

	logic [sswc_pkg::SLOT_W-1:0] idx;
	logic in_range;
	logic add_we;
	logic cmp_move;

	logic ram_we;
	logic [sswc_pkg::SLOT_W-1:0] ram_waddr;
	sswc_pkg::rec_t ram_wdata;
	logic ram_re;
	logic [sswc_pkg::SLOT_W-1:0] ram_raddr;
	logic [sswc_pkg::REC_W-1:0] ram_rdata;
	sswc_pkg::rec_t rd_rec;
	sswc_pkg::rec_t new_rec;
	sswc_pkg::rec_t shown;

	sswc_pkg::rsp_item_t res_d;
	sswc_pkg::rsp_item_t hold_q;
	sswc_pkg::rsp_item_t rsp_q;

	assign idx = item_q.slot_index[sswc_pkg::SLOT_W-1:0];
	assign in_range = item_q.slot_index < sswc_pkg::SLOTS_B;
	assign sts.cmp_last = ptr_q == sswc_pkg::SLOT_W'(sswc_pkg::SLOTS - 1);
	assign rd_rec = sswc_pkg::rec_t'(ram_rdata);

	assign new_rec = '{
		rtype: item_q.in_type, spicy: item_q.in_spicy, dry: item_q.in_dry,
		sweet: item_q.in_sweet, bitter: item_q.in_bitter, sour: item_q.in_sour,
		smooth: item_q.in_smooth
	};

	always_comb begin
		free_pad = '0;
		free_pad[sswc_pkg::SLOTS-1:0] = ~used_q;
		for (int g = 0; g < sswc_pkg::GRP_N; g++) begin
			grp_any_d[g] = |free_pad[g*sswc_pkg::GRP_SZ +: sswc_pkg::GRP_SZ];
			grp_pos_d[g] = '0;
			for (int b = sswc_pkg::GRP_SZ - 1; b >= 0; b--) begin
				if (free_pad[g*sswc_pkg::GRP_SZ + b]) begin
					grp_pos_d[g] = sswc_pkg::GRP_BW'(b);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		grp_any_s1 <= grp_any_d;
		grp_pos_s1 <= grp_pos_d;
	end

	// stage two: lowest group holding a free slot
	always_comb begin
		found = 1'b0;
		grp_sel = '0;
		for (int g = sswc_pkg::GRP_N - 1; g >= 0; g--) begin
			if (grp_any_s1[g]) begin
				found = 1'b1;
				grp_sel = sswc_pkg::GRP_IW'(g);
			end
		end
	end

	assign add_slot_w = {grp_sel, grp_pos_s1[grp_sel]};
	assign add_slot = add_slot_w[sswc_pkg::SLOT_W-1:0];

	assign add_we = ctl.add_go & found;
	assign cmp_move = ctl.cmp_step & used_q[ptr_q];

	// memory ports
	always_comb begin
		ram_we = add_we | cmp_move;
		ram_waddr = ctl.cmp_step ? wr_ptr_q : add_slot;
		ram_wdata = ctl.cmp_step ? rd_rec : new_rec;
		ram_re = ctl.load | (ctl.cmp_step & ~sts.cmp_last);
		if (ctl.load) begin
			ram_raddr = (cmd_item.cmd == sswc_pkg::CMD_CMP) ? '0 :
				cmd_item.slot_index[sswc_pkg::SLOT_W-1:0];
		end else begin
			ram_raddr = ptr_q + sswc_pkg::SLOT_W'(1);
		end
	end

	sswc_ram #(
		.WIDTH(sswc_pkg::REC_W),
		.DEPTH(sswc_pkg::SLOTS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			item_q <= cmd_item;
		end
	end

	always_comb begin
		cnt_d = cnt_q;
		if (add_we && item_q.in_type != sswc_pkg::EMPTY_CODE) begin
			cnt_d = cnt_q + 8'd1;
		end
		if (ctl.clr_go && in_range && used_q[idx]) begin
			cnt_d = cnt_q - 8'd1;
		end
	end

	// slot flags: a slot that is not valid reads as the empty record
	always_comb begin
		valid_d = valid_q;
		used_d = used_q;
		if (add_we) begin
			valid_d[add_slot] = 1'b1;
			used_d[add_slot] = item_q.in_type != sswc_pkg::EMPTY_CODE;
		end
		if (ctl.clr_go && in_range) begin
			valid_d[idx] = 1'b0;
			used_d[idx] = 1'b0;
		end
		if (ctl.cmp_step) begin
			// free the source slot, then claim the destination (may be the same)
			valid_d[ptr_q] = 1'b0;
			used_d[ptr_q] = 1'b0;
			if (used_q[ptr_q]) begin
				valid_d[wr_ptr_q] = 1'b1;
				used_d[wr_ptr_q] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			used_q <= '0;
			cnt_q <= '0;
			ptr_q <= '0;
			wr_ptr_q <= '0;
		end else begin
			cnt_q <= cnt_d;
			valid_q <= valid_d;
			used_q <= used_d;
			if (ctl.load) begin
				ptr_q <= '0;
				wr_ptr_q <= '0;
			end else if (ctl.cmp_step) begin
				if (used_q[ptr_q]) begin
					wr_ptr_q <= wr_ptr_q + sswc_pkg::SLOT_W'(1);
				end
				ptr_q <= ptr_q + sswc_pkg::SLOT_W'(1);
			end
		end
	end

	always_comb begin
		shown = sswc_pkg::EMPTY_REC;
		res_d.status = sswc_pkg::ST_OK;
		res_d.result_slot = item_q.slot_index;
		res_d.filled_count = cnt_d;
		case (item_q.cmd)
			sswc_pkg::CMD_ADD: begin
				if (found) begin
					res_d.result_slot = 8'(add_slot);
				end else begin
					res_d.status = sswc_pkg::ST_FULL;
					res_d.result_slot = sswc_pkg::NO_SLOT;
				end
			end
			sswc_pkg::CMD_CLR: begin
				if (!in_range) begin
					res_d.status = sswc_pkg::ST_RANGE;
				end
			end
			sswc_pkg::CMD_RD: begin
				if (!in_range) begin
					res_d.status = sswc_pkg::ST_RANGE;
				end else if (valid_q[idx]) begin
					shown = rd_rec;
				end
			end
			sswc_pkg::CMD_CMP: begin
				res_d.result_slot = 8'd0;
			end
			default: begin
				res_d.status = sswc_pkg::ST_OK;
			end
		endcase
		res_d.out_type = shown.rtype;
		res_d.out_spicy = shown.spicy;
		res_d.out_dry = shown.dry;
		res_d.out_sweet = shown.sweet;
		res_d.out_bitter = shown.bitter;
		res_d.out_sour = shown.sour;
		res_d.out_smooth = shown.smooth;
	end

	always_ff @(posedge clk) begin
		if (ctl.hold_from_res) begin
			hold_q <= res_d;
		end
		if (ctl.out_from_res) begin
			rsp_q <= res_d;
		end else if (ctl.out_from_hold) begin
			rsp_q <= hold_q;
		end
	end

	assign rsp_item = rsp_q;

endmodule

// File: design/sswc_ctrl.sv
`timescale 1ns / 1ps
// Controller: command sequencing and both channel handshakes.
module sswc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	input  logic [1:0]        cmd_code,
	output logic              cmd_stall,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output sswc_pkg::dp_ctl_t ctl,
	input  sswc_pkg::dp_sts_t sts
);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_ADD  = 6'b000010,
		S_CLR  = 6'b000100,
		S_RD   = 6'b001000,
		S_CMP  = 6'b010000,
		S_WAIT = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic rsp_valid_q;
	logic take;
	logic out_free;
	logic fin;

	assign take = cmd_valid & (state_q == S_IDLE);
	assign out_free = ~rsp_valid_q | ~rsp_stall;
	assign fin = (state_q == S_ADD) | (state_q == S_CLR) | (state_q == S_RD) |
		((state_q == S_CMP) & sts.cmp_last);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					case (cmd_code)
						sswc_pkg::CMD_ADD: state_d = S_ADD;
						sswc_pkg::CMD_CLR: state_d = S_CLR;
						sswc_pkg::CMD_RD: state_d = S_RD;
						sswc_pkg::CMD_CMP: state_d = S_CMP;
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_ADD, S_CLR, S_RD: begin
				state_d = out_free ? S_IDLE : S_WAIT;
			end
			S_CMP: begin
				if (sts.cmp_last) begin
					state_d = out_free ? S_IDLE : S_WAIT;
				end
			end
			S_WAIT: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		ctl.load = take;
		ctl.add_go = state_q == S_ADD;
		ctl.clr_go = state_q == S_CLR;
		ctl.cmp_step = state_q == S_CMP;
		ctl.out_from_res = fin & out_free;
		ctl.hold_from_res = fin & ~out_free;
		ctl.out_from_hold = (state_q == S_WAIT) & out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.out_from_res || ctl.out_from_hold) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign cmd_stall = state_q != S_IDLE;
	assign rsp_valid = rsp_valid_q;

endmodule

// File: verif/slot_store_with_compaction_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the slot store with compaction: directed and random commands.
module slot_store_with_compaction_tb;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cmd_valid = 1'b0;
	logic                cmd_stall;
	sswc_pkg::cmd_item_t cmd_item = '0;
	logic                rsp_valid;
	logic                rsp_stall = 1'b0;
	sswc_pkg::rsp_item_t rsp_item;

	// shadow copy of the table, updated at every command transfer
	sswc_pkg::rec_t      table_copy [sswc_pkg::SLOTS];
	int                  filled_copy;
	sswc_pkg::rsp_item_t pending_rsp [$];
	int                  mismatch_cnt = 0;
	bit                  no_idle = 1'b0;
	int                  stall_left = 0;

	slot_store_with_compaction dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd_item  (cmd_item),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_item  (rsp_item)
	);

	always #5 clk = ~clk;

	function automatic bit is_free(input sswc_pkg::rec_t r);
		return r.rtype == sswc_pkg::EMPTY_CODE;
	endfunction

	// Applies one command to the shadow table and returns the expected response.
	function automatic sswc_pkg::rsp_item_t apply_cmd(input sswc_pkg::cmd_item_t it);
		sswc_pkg::rsp_item_t r;
		sswc_pkg::rec_t      shown;
		int                  pick;
		int                  wr;
		shown = sswc_pkg::EMPTY_REC;
		r = '0;
		r.status = sswc_pkg::ST_OK;
		case (it.cmd)
			sswc_pkg::CMD_ADD: begin
				pick = -1;
				for (int i = sswc_pkg::SLOTS - 1; i >= 0; i--) begin
					if (is_free(table_copy[i]))
						pick = i;
				end
				if (pick < 0) begin
					r.status = sswc_pkg::ST_FULL;
					r.result_slot = sswc_pkg::NO_SLOT;
				end else begin
					r.result_slot = 8'(pick);
					table_copy[pick] = {it.in_type, it.in_spicy, it.in_dry, it.in_sweet,
						it.in_bitter, it.in_sour, it.in_smooth};
				end
			end
			sswc_pkg::CMD_CLR: begin
				r.result_slot = it.slot_index;
				if (int'(it.slot_index) >= sswc_pkg::SLOTS)
					r.status = sswc_pkg::ST_RANGE;
				else
					table_copy[it.slot_index] = sswc_pkg::EMPTY_REC;
			end
			sswc_pkg::CMD_RD: begin
				r.result_slot = it.slot_index;
				if (int'(it.slot_index) >= sswc_pkg::SLOTS)
					r.status = sswc_pkg::ST_RANGE;
				else
					shown = table_copy[it.slot_index];
			end
			sswc_pkg::CMD_CMP: begin
				// stable: occupied records keep their relative order
				wr = 0;
				for (int i = 0; i < sswc_pkg::SLOTS; i++) begin
					if (!is_free(table_copy[i])) begin
						table_copy[wr] = table_copy[i];
						wr++;
					end
				end
				for (int i = wr; i < sswc_pkg::SLOTS; i++)
					table_copy[i] = sswc_pkg::EMPTY_REC;
				r.result_slot = 8'd0;
			end
			default: begin
				r.status = sswc_pkg::ST_OK;
			end
		endcase
		filled_copy = 0;
		for (int i = 0; i < sswc_pkg::SLOTS; i++) begin
			if (!is_free(table_copy[i]))
				filled_copy++;
		end
		r.out_type = shown.rtype;
		r.out_spicy = shown.spicy;
		r.out_dry = shown.dry;
		r.out_sweet = shown.sweet;
		r.out_bitter = shown.bitter;
		r.out_sour = shown.sour;
		r.out_smooth = shown.smooth;
		r.filled_count = 8'(filled_copy);
		return r;
	endfunction

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (no_idle || roll < 50)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	task automatic flag_mismatch(input string msg);
		$display("[%0t] MISMATCH: %s", $time, msg);
		mismatch_cnt++;
	endtask

	task automatic cmp_field(input string name, input logic [7:0] got, input logic [7:0] want);
		if (got !== want)
			flag_mismatch($sformatf("%s got %h expected %h", name, got, want));
	endtask

	task automatic check_rsp(input sswc_pkg::rsp_item_t got);
		sswc_pkg::rsp_item_t want;
		if (pending_rsp.size() == 0) begin
			flag_mismatch($sformatf("response with nothing outstanding: %h", got));
		end else begin
			want = pending_rsp.pop_front();
			cmp_field("status", 8'(got.status), 8'(want.status));
			cmp_field("result_slot", got.result_slot, want.result_slot);
			cmp_field("out_type", got.out_type, want.out_type);
			cmp_field("out_spicy", got.out_spicy, want.out_spicy);
			cmp_field("out_dry", got.out_dry, want.out_dry);
			cmp_field("out_sweet", got.out_sweet, want.out_sweet);
			cmp_field("out_bitter", got.out_bitter, want.out_bitter);
			cmp_field("out_sour", got.out_sour, want.out_sour);
			cmp_field("out_smooth", got.out_smooth, want.out_smooth);
			cmp_field("filled_count", got.filled_count, want.filled_count);
		end
	endtask

	// response side: check each transfer, stall at random
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			check_rsp(rsp_item);
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= 1'b0;
			stall_left <= pick_gap();
		end
	end

	// Drives one command; returns at the edge where it transfers, valid still high.
	task automatic send_cmd(input sswc_pkg::cmd_item_t it);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd_item <= it;
		forever begin
			@(posedge clk);
			if (!cmd_stall)
				break;
		end
		pending_rsp.push_back(apply_cmd(it));
	endtask

	function automatic sswc_pkg::cmd_item_t make_item(input logic [1:0] op,
		input logic [7:0] idx, input logic [7:0] rtype, input logic [7:0] fill);
		sswc_pkg::cmd_item_t it;
		it.cmd = op;
		it.slot_index = idx;
		it.in_type = rtype;
		it.in_spicy = fill;
		it.in_dry = fill;
		it.in_sweet = fill;
		it.in_bitter = fill;
		it.in_sour = fill;
		it.in_smooth = fill;
		return it;
	endfunction

	function automatic sswc_pkg::cmd_item_t rand_item(input logic [1:0] op);
		sswc_pkg::cmd_item_t it;
		it.cmd = op;
		if ($urandom_range(0, 9) == 0)
			it.slot_index = 8'($urandom_range(sswc_pkg::SLOTS, 255));
		else
			it.slot_index = 8'($urandom_range(0, sswc_pkg::SLOTS - 1));
		it.in_type = ($urandom_range(0, 9) == 0) ? sswc_pkg::EMPTY_CODE : 8'($urandom);
		it.in_spicy = 8'($urandom);
		it.in_dry = 8'($urandom);
		it.in_sweet = 8'($urandom);
		it.in_bitter = 8'($urandom);
		it.in_sour = 8'($urandom);
		it.in_smooth = 8'($urandom);
		return it;
	endfunction

	// table right after reset, reads at both ends and past the end, then a compact
	task automatic test_reset_state();
		send_cmd(make_item(sswc_pkg::CMD_RD, 8'd0, 8'd0, 8'd0));
		send_cmd(make_item(sswc_pkg::CMD_RD, 8'(sswc_pkg::SLOTS - 1), 8'd0, 8'd0));
		send_cmd(make_item(sswc_pkg::CMD_RD, sswc_pkg::SLOTS_B, 8'd0, 8'd0));
		send_cmd(make_item(sswc_pkg::CMD_RD, 8'hFF, 8'hFF, 8'hFF));
		send_cmd(make_item(sswc_pkg::CMD_CMP, 8'hFF, 8'hFF, 8'hFF));
	endtask

	task automatic test_add_clear_read();
		send_cmd(make_item(sswc_pkg::CMD_ADD, 8'hFF, 8'h00, 8'h00));
		send_cmd(make_item(sswc_pkg::CMD_ADD, 8'h00, 8'hFF, 8'hFF));
		// empty-typed add lands in slot 2 but leaves it free
		send_cmd(make_item(sswc_pkg::CMD_ADD, 8'h00, sswc_pkg::EMPTY_CODE, 8'hA5));
		send_cmd(make_item(sswc_pkg::CMD_RD, 8'd2, 8'd0, 8'd0));
		send_cmd(make_item(sswc_pkg::CMD_ADD, 8'h5A, 8'h81, 8'h5A));
		send_cmd(make_item(sswc_pkg::CMD_RD, 8'd2, 8'd0, 8'd0));
		send_cmd(make_item(sswc_pkg::CMD_CLR, 8'd200, 8'd0, 8'd0));
		send_cmd(make_item(sswc_pkg::CMD_CLR, sswc_pkg::SLOTS_B, 8'd0, 8'd0));
		send_cmd(make_item(sswc_pkg::CMD_CLR, 8'd5, 8'd0, 8'd0));
		send_cmd(make_item(sswc_pkg::CMD_CLR, 8'd0, 8'd0, 8'd0));
		send_cmd(make_item(sswc_pkg::CMD_RD, 8'd0, 8'd0, 8'd0));
		send_cmd(make_item(sswc_pkg::CMD_RD, 8'd1, 8'd0, 8'd0));
		send_cmd(make_item(sswc_pkg::CMD_CMP, 8'd7, 8'd3, 8'd9));
		send_cmd(make_item(sswc_pkg::CMD_RD, 8'd0, 8'd0, 8'd0));
		send_cmd(make_item(sswc_pkg::CMD_RD, 8'd1, 8'd0, 8'd0));
	endtask

	// fill every slot, then add into a full table, free two holes, compact and refill one
	task automatic test_full_table();
		sswc_pkg::cmd_item_t it;
		while (filled_copy < sswc_pkg::SLOTS) begin
			it = rand_item(sswc_pkg::CMD_ADD);
			if (it.in_type == sswc_pkg::EMPTY_CODE)
				it.in_type = 8'd0;
			send_cmd(it);
		end
		send_cmd(rand_item(sswc_pkg::CMD_ADD));
		send_cmd(make_item(sswc_pkg::CMD_RD, 8'(sswc_pkg::SLOTS - 1), 8'd0, 8'd0));
		send_cmd(make_item(sswc_pkg::CMD_CLR, 8'd64, 8'd0, 8'd0));
		send_cmd(make_item(sswc_pkg::CMD_CLR, 8'd3, 8'd0, 8'd0));
		send_cmd(make_item(sswc_pkg::CMD_CMP, 8'd0, 8'd0, 8'd0));
		send_cmd(make_item(sswc_pkg::CMD_RD, 8'(sswc_pkg::SLOTS - 2), 8'd0, 8'd0));
		send_cmd(make_item(sswc_pkg::CMD_ADD, 8'd0, 8'h7E, 8'h3C));
		send_cmd(make_item(sswc_pkg::CMD_RD, 8'(sswc_pkg::SLOTS - 2), 8'd0, 8'd0));
	endtask

	// phases that fill, drain or mix the table; some phases run with no idling
	task automatic test_random_mix(input int n_items);
		int roll;
		int mode;
		int w_add;
		int w_clr;
		int w_rd;
		logic [1:0] op;
		mode = 0;
		for (int k = 0; k < n_items; k++) begin
			if (k % 150 == 0) begin
				mode = $urandom_range(0, 2);
				no_idle <= ($urandom_range(0, 3) == 0);
			end
			case (mode)
				0: begin w_add = 90; w_clr = 93; w_rd = 98; end
				1: begin w_add = 20; w_clr = 70; w_rd = 92; end
				default: begin w_add = 40; w_clr = 60; w_rd = 92; end
			endcase
			roll = $urandom_range(0, 99);
			if (roll < w_add)
				op = sswc_pkg::CMD_ADD;
			else if (roll < w_clr)
				op = sswc_pkg::CMD_CLR;
			else if (roll < w_rd)
				op = sswc_pkg::CMD_RD;
			else
				op = sswc_pkg::CMD_CMP;
			send_cmd(rand_item(op));
		end
		no_idle <= 1'b0;
	endtask

	initial begin
		for (int i = 0; i < sswc_pkg::SLOTS; i++)
			table_copy[i] = sswc_pkg::EMPTY_REC;
		filled_copy = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_add_clear_read();
		test_full_table();
		test_random_mix(1150);
		cmd_valid <= 1'b0;
		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (2 * sswc_pkg::SLOTS + 20) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#50_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
